### rtl/pulse_period_histogram_unit_defines.svh
// Assertion macros for the checker file of the period histogram unit.
`ifndef PULSE_PERIOD_HISTOGRAM_UNIT_DEFINES_SVH
`define PULSE_PERIOD_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPH_ASSERT_IMP(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPH_ASSERT_NXT(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/pph_pkg.sv
package pph_pkg;

  localparam int unsigned NUM_BINS_DEF   = 100;
  localparam int unsigned RUN_LENGTH_DEF = 1000;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned LIMIT_W  = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'h3FF;

  typedef enum logic [MODE_W-1:0] {
    MODE_START   = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED = 3'd0,
    ST_FIRST   = 3'd1,
    ST_BINNED  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_IGNORED = 3'd4,
    ST_READ    = 3'd5
  } status_t;

  // Work the back end has to do for one item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_BIN    = 2'd1,
    OP_READ   = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_RMW   = 2'd2
  } back_state_t;

  typedef struct packed {
    op_t                op;
    status_t            status;
    logic [STAMP_W-1:0] interval;
    logic               run_done;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

### rtl/pph_front.sv
module pph_front #(
  parameter int unsigned NUM_BINS   = pph_pkg::NUM_BINS_DEF,
  parameter int unsigned RUN_LENGTH = pph_pkg::RUN_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pph_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pph_pkg::MODE_W-1:0]     in_mode,
  input  logic [pph_pkg::STAMP_W-1:0]    in_capture_stamp,
  input  logic [pph_pkg::IDX_W-1:0]      in_bin_index,
  input  pph_pkg::back_stat_t            back_stat,
  input  logic                           q_ready,
  output logic                           q_push,
  output pph_pkg::cmd_t                  q_cmd,
  output logic [$clog2(NUM_BINS)-1:0]    q_addr
);
  import pph_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned CW = $clog2(RUN_LENGTH + 1);

  logic [LIMIT_W-1:0] limit_r;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic               edge_seen_r, edge_seen_nxt;
  logic               stopped_r, stopped_nxt;
  logic [CW-1:0]      meas_cnt_r, meas_cnt_nxt;

  logic [STAMP_W-1:0] interval;
  logic [STAMP_W-1:0] offset;
  logic               in_range;
  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [CW-1:0]      cnt_inc;
  logic               accept;

  assign in_stall = !q_ready || back_stat.init_busy;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;

  assign interval = in_capture_stamp - last_stamp_r;
  assign offset   = interval - STAMP_W'(limit_r);
  assign in_range = offset < STAMP_W'(NUM_BINS);
  assign idx_ext  = 32'(in_bin_index);
  assign idx_ok   = idx_ext < 32'(NUM_BINS);
  assign cnt_inc  = meas_cnt_r + 1'b1;

  always_comb begin
    last_stamp_nxt  = last_stamp_r;
    edge_seen_nxt   = edge_seen_r;
    stopped_nxt     = stopped_r;
    meas_cnt_nxt    = meas_cnt_r;
    q_cmd.op        = OP_REPORT;
    q_cmd.status    = ST_IGNORED;
    q_cmd.interval  = '0;
    q_addr          = '0;
    case (in_mode)
      MODE_START: begin
        last_stamp_nxt = '0;
        edge_seen_nxt  = 1'b0;
        stopped_nxt    = 1'b0;
        meas_cnt_nxt   = '0;
        q_cmd.op       = OP_CLEAR;
        q_cmd.status   = ST_STARTED;
      end
      MODE_CAPTURE: begin
        if (stopped_r) begin
          q_cmd.status = ST_IGNORED;
        end else if (!edge_seen_r) begin
          edge_seen_nxt  = 1'b1;
          last_stamp_nxt = in_capture_stamp;
          q_cmd.status   = ST_FIRST;
        end else begin
          last_stamp_nxt = in_capture_stamp;
          q_cmd.interval = interval;
          if (in_range) begin
            q_cmd.op     = OP_BIN;
            q_cmd.status = ST_BINNED;
            q_addr       = offset[AW-1:0];
            meas_cnt_nxt = cnt_inc;
            if (cnt_inc == CW'(RUN_LENGTH)) begin
              stopped_nxt = 1'b1;
            end
          end else begin
            q_cmd.status = ST_RANGE;
            stopped_nxt  = 1'b1;
          end
        end
      end
      MODE_READ: begin
        q_cmd.status = ST_READ;
        if (idx_ok) begin
          q_cmd.op = OP_READ;
          q_addr   = idx_ext[AW-1:0];
        end
      end
      default: begin
        q_cmd.status = ST_IGNORED;
      end
    endcase
    q_cmd.run_done = stopped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= LIMIT_RESET;
      last_stamp_r <= '0;
      edge_seen_r  <= 1'b0;
      stopped_r    <= 1'b0;
      meas_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (accept) begin
        last_stamp_r <= last_stamp_nxt;
        edge_seen_r  <= edge_seen_nxt;
        stopped_r    <= stopped_nxt;
        meas_cnt_r   <= meas_cnt_nxt;
      end
    end
  end

endmodule

### rtl/pph_fifo.sv
module pph_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = pph_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);
  // DEPTH is a power of two so the pointers wrap naturally.
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] fill_r;

  assign ready = fill_r != NW'(DEPTH);
  assign valid = fill_r != '0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

### rtl/pph_back.sv
module pph_back #(
  parameter int unsigned NUM_BINS = pph_pkg::NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pph_pkg::cmd_t                 q_cmd,
  input  logic [$clog2(NUM_BINS)-1:0]   q_addr,
  output logic                          q_pop,
  output pph_pkg::back_stat_t           back_stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pph_pkg::STATUS_W-1:0]  out_status,
  output logic [pph_pkg::STAMP_W-1:0]   out_interval,
  output logic [pph_pkg::COUNT_W-1:0]   out_bin_count,
  output logic                          out_run_done
);
  import pph_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BINS);

  logic [COUNT_W-1:0] bin_mem [NUM_BINS];
  logic [COUNT_W-1:0] rd_data_r;

  back_state_t        state_r, state_nxt;
  logic               init_r, init_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [STAMP_W-1:0] out_interval_r, out_interval_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_done_r, out_done_nxt;

  logic               out_free;
  logic               we, re;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wdata;
  logic [COUNT_W-1:0] count_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign count_inc = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;

  assign back_stat.init_busy = init_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_interval  = out_interval_r;
  assign out_bin_count = out_count_r;
  assign out_run_done  = out_done_r;

  always_comb begin
    state_nxt        = state_r;
    init_nxt         = init_r;
    clr_addr_nxt     = clr_addr_r;
    cmd_nxt          = cmd_r;
    addr_nxt         = addr_r;
    q_pop            = 1'b0;
    we               = 1'b0;
    re               = 1'b0;
    waddr            = addr_r;
    wdata            = count_inc;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_interval_nxt = out_interval_r;
    out_count_nxt    = out_count_r;
    out_done_nxt     = out_done_r;
    case (state_r)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = '0;
        if (clr_addr_r == AW'(NUM_BINS - 1)) begin
          state_nxt = B_IDLE;
          init_nxt  = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          addr_nxt = q_addr;
          case (q_cmd.op)
            OP_BIN, OP_READ: begin
              re        = 1'b1;
              state_nxt = B_RMW;
            end
            OP_CLEAR: begin
              out_valid_nxt    = 1'b1;
              out_status_nxt   = q_cmd.status;
              out_interval_nxt = q_cmd.interval;
              out_count_nxt    = '0;
              out_done_nxt     = q_cmd.run_done;
              clr_addr_nxt     = '0;
              state_nxt        = B_CLEAR;
            end
            default: begin
              out_valid_nxt    = 1'b1;
              out_status_nxt   = q_cmd.status;
              out_interval_nxt = q_cmd.interval;
              out_count_nxt    = '0;
              out_done_nxt     = q_cmd.run_done;
            end
          endcase
        end
      end
      B_RMW: begin
        // The output register was free when the item was popped.
        out_valid_nxt    = 1'b1;
        out_status_nxt   = cmd_r.status;
        out_interval_nxt = cmd_r.interval;
        out_done_nxt     = cmd_r.run_done;
        if (cmd_r.op == OP_BIN) begin
          we            = 1'b1;
          out_count_nxt = count_inc;
        end else begin
          out_count_nxt = rd_data_r;
        end
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      bin_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= bin_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    addr_r         <= addr_nxt;
    out_status_r   <= out_status_nxt;
    out_interval_r <= out_interval_nxt;
    out_count_r    <= out_count_nxt;
    out_done_r     <= out_done_nxt;
  end

endmodule

### rtl/pulse_period_histogram_unit.sv
// Period histogram of input-capture timestamps. A start item (mode 0) zeroes every
// bin and the run state, a capture item (mode 1) measures the wrapped interval to the
// previous timestamp and counts it into bin (interval - lower_limit), and a read item
// (mode 2) returns one bin's count. An out-of-range interval or the RUN_LENGTH-th
// binned interval stops the run; later captures report as ignored. Every item yields
// exactly one result item, in order. The front end takes one item per cycle, unless
// in_stall is high, into a two-entry queue; the back end owns the bin memory, a
// single-port array with a registered read. A capture that bins or an in-range read
// passes through B_RMW after its memory read (increment and write-back for a capture),
// every other item is answered from B_IDLE, and a start item then runs a B_CLEAR sweep
// that zeroes the memory. After reset the same sweep runs, during which in_stall is
// high; the configuration port stays writable throughout. Write lower_limit only
// while the block is idle.
module pulse_period_histogram_unit #(
  parameter int unsigned NUM_BINS   = pph_pkg::NUM_BINS_DEF,
  parameter int unsigned RUN_LENGTH = pph_pkg::RUN_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pph_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pph_pkg::MODE_W-1:0]    in_mode,
  input  logic [pph_pkg::STAMP_W-1:0]   in_capture_stamp,
  input  logic [pph_pkg::IDX_W-1:0]     in_bin_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pph_pkg::STATUS_W-1:0]  out_status,
  output logic [pph_pkg::STAMP_W-1:0]   out_interval,
  output logic [pph_pkg::COUNT_W-1:0]   out_bin_count,
  output logic                          out_run_done
);
  import pph_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned QW = $bits(cmd_t) + AW;

  // Front-end handoff: the classified command plus the bin address it touches.
  cmd_t          push_cmd, pop_cmd;
  logic [AW-1:0] push_addr, pop_addr;
  logic          q_push, q_pop, q_ready, q_valid;
  logic [QW-1:0] q_head;
  back_stat_t    back_stat;

  pph_front #(
    .NUM_BINS   (NUM_BINS),
    .RUN_LENGTH (RUN_LENGTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_capture_stamp (in_capture_stamp),
    .in_bin_index     (in_bin_index),
    .back_stat        (back_stat),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_cmd            (push_cmd),
    .q_addr           (push_addr)
  );

  pph_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_cmd, push_addr}),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign pop_cmd  = q_head[QW-1:AW];
  assign pop_addr = q_head[AW-1:0];

  // The back end works strictly in queue order, so a read always sees the
  // write-back of every capture accepted before it.
  pph_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (pop_cmd),
    .q_addr        (pop_addr),
    .q_pop         (q_pop),
    .back_stat     (back_stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_interval  (out_interval),
    .out_bin_count (out_bin_count),
    .out_run_done  (out_run_done)
  );

endmodule

### rtl/pph_checker.sv
`include "pulse_period_histogram_unit_defines.svh"

module pph_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pph_pkg::STATUS_W-1:0]  out_status,
  input logic [pph_pkg::STAMP_W-1:0]   out_interval,
  input logic [pph_pkg::COUNT_W-1:0]   out_bin_count,
  input logic                          out_run_done
);
  import pph_pkg::*;

  `PPH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_interval) &&
    $stable(out_bin_count) && $stable(out_run_done), "stalled result item changed")

  `PPH_ASSERT_IMP(a_interval_only_measured, clk, rst_n,
    out_valid && out_status != ST_BINNED && out_status != ST_RANGE,
    out_interval == '0, "interval reported without a measurement")

  `PPH_ASSERT_IMP(a_range_stops_run, clk, rst_n, out_valid && out_status == ST_RANGE,
    out_run_done && out_bin_count == '0, "out-of-range item did not stop the run")

  `PPH_ASSERT_IMP(a_start_restarts, clk, rst_n, out_valid && out_status == ST_STARTED,
    !out_run_done && out_bin_count == '0, "start item left the run stopped")

endmodule

bind pulse_period_histogram_unit pph_checker u_pph_checker (.*);

### bench/testbench.sv
// Regression bench for the pulse period histogram unit.
//
// A handful of directed items come first. They cover a capture before any start,
// wrapped intervals at both ends of the bin range, reads inside and past the bins,
// the unused mode, the out-of-range stop and a capture after a stop. Random runs
// follow under several lower_limit settings, and one run is long enough to reach the
// measurement limit. A scoreboard class keeps its own copy of the histogram state.
// For every accepted input item it works out the one result item, and it checks each
// result item in order as it leaves the block.
module testbench;
  import pph_pkg::*;

  localparam int unsigned NUM_BINS   = NUM_BINS_DEF;
  localparam int unsigned RUN_LENGTH = RUN_LENGTH_DEF;

  // Mode code that the block leaves unused; it must come back as ignored.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned IDX_TOP = (1 << IDX_W) - 1;

  // The back end sweeps NUM_BINS entries after a start, so allow that much
  // settling time before touching the register or ending the run.
  localparam int unsigned SETTLE_CYCLES   = NUM_BINS + 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;

  typedef struct {
    status_t            status;
    logic [STAMP_W-1:0] interval;
    logic [COUNT_W-1:0] count;
    logic               run_done;
  } period_report_t;

  // Histogram state mirror plus the queue of result items still owed by the block.
  class histogram_scoreboard;
    logic [LIMIT_W-1:0] lower_limit;
    logic [COUNT_W-1:0] bin_counts [NUM_BINS];
    logic [STAMP_W-1:0] last_stamp;
    bit                 edge_seen;
    bit                 stopped;
    int unsigned        binned_total;
    period_report_t     pending_reports [$];
    int                 error_count;

    function new();
      lower_limit = LIMIT_RESET;
      error_count = 0;
      clear_run();
    endfunction

    function void clear_run();
      foreach (bin_counts[i]) bin_counts[i] = '0;
      last_stamp   = '0;
      edge_seen    = 1'b0;
      stopped      = 1'b0;
      binned_total = 0;
    endfunction

    function void log_accepted_item(logic [MODE_W-1:0] mode, logic [STAMP_W-1:0] stamp,
                                     logic [IDX_W-1:0] idx);
      period_report_t     rep;
      logic [STAMP_W-1:0] offset;
      rep.status   = ST_IGNORED;
      rep.interval = '0;
      rep.count    = '0;
      case (mode)
        MODE_START: begin
          clear_run();
          rep.status = ST_STARTED;
        end
        MODE_CAPTURE: begin
          if (stopped) begin
            rep.status = ST_IGNORED;
          end else if (!edge_seen) begin
            edge_seen  = 1'b1;
            last_stamp = stamp;
            rep.status = ST_FIRST;
          end else begin
            rep.interval = stamp - last_stamp;
            last_stamp   = stamp;
            offset       = rep.interval - {{(STAMP_W-LIMIT_W){1'b0}}, lower_limit};
            if (offset < NUM_BINS) begin
              if (bin_counts[offset] != COUNT_MAX) bin_counts[offset]++;
              rep.count = bin_counts[offset];
              binned_total++;
              if (binned_total >= RUN_LENGTH) stopped = 1'b1;
              rep.status = ST_BINNED;
            end else begin
              stopped    = 1'b1;
              rep.status = ST_RANGE;
            end
          end
        end
        MODE_READ: begin
          if (idx < NUM_BINS) rep.count = bin_counts[idx];
          rep.status = ST_READ;
        end
        default: ;
      endcase
      rep.run_done = stopped;
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string field, logic [STAMP_W-1:0] expected,
                                logic [STAMP_W-1:0] actual);
      if (expected !== actual) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expected,
                 actual);
        error_count++;
      end
    endfunction

    function void check_result_item(logic [STATUS_W-1:0] status,
                                    logic [STAMP_W-1:0] interval,
                                    logic [COUNT_W-1:0] count, logic run_done);
      period_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual status %0d", $time,
                 status);
        error_count++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("status", want.status, status);
      compare_field("interval", want.interval, interval);
      compare_field("bin_count", want.count, count);
      compare_field("run_done", want.run_done, run_done);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [STAMP_W-1:0]  in_capture_stamp;
  logic [IDX_W-1:0]    in_bin_index;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [STAMP_W-1:0]  out_interval;
  logic [COUNT_W-1:0]  out_bin_count;
  logic                out_run_done;

  histogram_scoreboard board = new();

  // Idle percentages for each side. The main sequence changes them between phases.
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 54;
  // Set by the main sequence to ask the receiver for one long hold-off.
  bit hold_off_req = 1'b0;

  // Stimulus bookkeeping: the running timer value and the limit the block holds.
  logic [STAMP_W-1:0] stamp_now;
  logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

  pulse_period_histogram_unit #(
    .NUM_BINS  (NUM_BINS),
    .RUN_LENGTH(RUN_LENGTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_capture_stamp(in_capture_stamp),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_interval    (out_interval),
    .out_bin_count   (out_bin_count),
    .out_run_done    (out_run_done)
  );

  always #6 clk = ~clk;

  // Receiver. It stalls at random, except during a requested hold-off, which it
  // counts down here so the sender keeps pushing and the block backs up.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every result item that leaves the block is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result_item(out_status, out_interval, out_bin_count, out_run_done);
    end
  end

  // Watchdog: a long stretch with no item moving on either channel means a hang.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("pulse_period_histogram_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with random idle cycles ahead of it, and returns at the clock
  // edge where the block takes it. Valid stays high on return so that a following
  // item goes out back to back.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [STAMP_W-1:0] stamp,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_capture_stamp <= stamp;
    in_bin_index     <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.log_accepted_item(mode, stamp, idx);
  endtask

  // Advances the timer by the given interval and sends a capture at the new value.
  task automatic send_capture(input logic [STAMP_W-1:0] interval);
    stamp_now = stamp_now + interval;
    send_item(MODE_CAPTURE, stamp_now, IDX_W'($urandom_range(IDX_TOP)));
  endtask

  // Drops valid and waits until every predicted result item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
  endtask

  // lower_limit is written only with the block idle, including the clearing sweep
  // that a start may still have running behind its result item.
  task automatic write_lower_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= LIMIT_W'($urandom);
    board.lower_limit  = value;
    limit_now          = value;
  endtask

  // Short runs: a start, then mostly in-range captures with random bins, mixed with
  // reads, the odd out-of-range interval, boundary intervals, stray starts and
  // unused-mode noise.
  task automatic histogram_runs(input int unsigned item_budget);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    logic [STAMP_W-1:0] base;
    sent = 0;
    while (sent < item_budget) begin
      send_item(MODE_START, $urandom, IDX_W'($urandom_range(IDX_TOP)));
      stamp_now = $urandom;
      run_len   = $urandom_range(5, 40);
      sent      = sent + 1 + run_len;
      repeat (run_len) begin
        base = {{(STAMP_W-LIMIT_W){1'b0}}, limit_now};
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_capture(base + $urandom_range(NUM_BINS - 1));
        end else if (pick < 74) begin
          send_capture($urandom);
        end else if (pick < 76) begin
          // One tick either side of the bin range.
          send_capture($urandom_range(1) ? base + NUM_BINS : base - 1);
        end else if (pick < 90) begin
          send_item(MODE_READ, $urandom, IDX_W'($urandom_range(IDX_TOP)));
        end else if (pick < 94) begin
          send_item(MODE_READ, $urandom, IDX_W'($urandom_range(NUM_BINS - 1)));
        end else if (pick < 97) begin
          send_item(MODE_UNUSED, $urandom, IDX_W'($urandom_range(IDX_TOP)));
        end else begin
          send_item(MODE_START, $urandom, IDX_W'($urandom_range(IDX_TOP)));
        end
      end
    end
  endtask

  // One run that goes all the way to the measurement limit. Most intervals land in
  // one favored bin so its count climbs high; the rest scatter. A few captures past
  // the limit must come back ignored.
  task automatic full_length_run();
    int unsigned favored;
    logic [STAMP_W-1:0] base;
    favored   = $urandom_range(NUM_BINS - 1);
    base      = {{(STAMP_W-LIMIT_W){1'b0}}, limit_now};
    send_item(MODE_START, $urandom, IDX_W'($urandom_range(IDX_TOP)));
    stamp_now = $urandom;
    send_capture($urandom);
    for (int unsigned n = 0; n < RUN_LENGTH + 6; n++) begin
      if ($urandom_range(99) < 90) send_capture(base + favored);
      else send_capture(base + $urandom_range(NUM_BINS - 1));
      if ($urandom_range(49) == 0) begin
        send_item(MODE_READ, $urandom, IDX_W'(favored));
      end
    end
    send_item(MODE_READ, $urandom, IDX_W'(favored));
  endtask

  initial begin : main_sequence
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_mode          <= MODE_START;
    in_capture_stamp <= '0;
    in_bin_index     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items, with lower_limit still at its reset value. Captures are
    // recorded before any start, and the second one wraps the timer.
    send_item(MODE_CAPTURE, 32'hFFFF_FFF0, 7'h7F);
    send_item(MODE_CAPTURE, 32'h0000_0022, 7'h00);
    send_item(MODE_CAPTURE, 32'h0000_00B7, 7'h00);
    // Reads of both end bins, one just past them, the top index and an empty bin.
    send_item(MODE_READ, 32'h0000_0000, 7'd0);
    send_item(MODE_READ, 32'hFFFF_FFFF, 7'd99);
    send_item(MODE_READ, 32'h0000_0000, 7'd100);
    send_item(MODE_READ, 32'hFFFF_FFFF, 7'h7F);
    send_item(MODE_READ, 32'h0000_0000, 7'd50);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 7'h7F);
    // An interval one below the limit wraps the offset and stops the run; the
    // capture after that is ignored and the bins keep their counts.
    send_item(MODE_CAPTURE, 32'h0000_00E8, 7'h00);
    send_item(MODE_CAPTURE, 32'h0000_0124, 7'h00);
    send_item(MODE_READ, 32'h0000_0000, 7'd0);
    // The largest possible interval, then the first interval past the last bin.
    send_item(MODE_START, 32'hFFFF_FFFF, 7'h7F);
    send_item(MODE_CAPTURE, 32'h0000_0000, 7'h00);
    send_item(MODE_CAPTURE, 32'hFFFF_FFFF, 7'h7F);
    send_item(MODE_START, 32'h0000_0000, 7'h00);
    send_item(MODE_CAPTURE, 32'h8000_0000, 7'h00);
    send_item(MODE_CAPTURE, 32'h8000_0095, 7'h00);
    send_item(MODE_CAPTURE, 32'h8000_012B, 7'h00);
    send_item(MODE_START, 32'h5555_5555, 7'h2A);
    send_item(MODE_READ, 32'hAAAA_AAAA, 7'd99);

    // Sender idles less than the receiver.
    write_lower_limit('0);
    histogram_runs(250);
    // Long receiver hold-off while the sender keeps offering items.
    hold_off_req = 1'b1;
    histogram_runs(60);
    write_lower_limit({LIMIT_W{1'b1}});
    histogram_runs(200);

    // Receiver idles less than the sender.
    drain_results();
    send_idle_pct = 54;
    recv_idle_pct = 19;
    write_lower_limit(14'd9950);
    histogram_runs(250);
    write_lower_limit(LIMIT_W'($urandom_range(50, 9950)));
    histogram_runs(200);

    // Neither side idles.
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_lower_limit(LIMIT_W'($urandom_range(50, 9950)));
    full_length_run();
    write_lower_limit(LIMIT_W'($urandom));
    histogram_runs(200);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.error_count == 0) begin
      $display("pulse_period_histogram_unit regression: pass");
    end else begin
      $display("pulse_period_histogram_unit regression: fail");
    end
    $finish;
  end

endmodule
